### hw/rtl/stgvs_pkg.sv
// Shared constants for the segment table victim selector.
package stgvs_pkg;

    // Table geometry defaults
    localparam int SLOT_COUNT_DEF = 1024;
    localparam int KIND_BITS_DEF  = 2;

    // Command codes
    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_SEAL   = 3'd1;
    localparam logic [2:0] CMD_CLEAN  = 3'd2;
    localparam logic [2:0] CMD_FREE   = 3'd3;
    localparam logic [2:0] CMD_SETLIV = 3'd4;
    localparam logic [2:0] CMD_VICTIM = 3'd5;

    // Slot states
    localparam logic [1:0] SLOT_FREE   = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE = 2'd1;
    localparam logic [1:0] SLOT_SEALED = 2'd2;
    localparam logic [1:0] SLOT_CLEAN  = 2'd3;

    // Result status codes
    localparam logic [1:0] RES_DONE    = 2'd0;
    localparam logic [1:0] RES_NONE    = 2'd1;
    localparam logic [1:0] RES_IGNORED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIZE   = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;

    // Liveness percent constants
    localparam logic [6:0] PCT_NO_BEST = 7'd101;
    localparam logic [6:0] PCT_SCALE   = 7'd100;

endpackage

### hw/rtl/stgvs_ram.sv
// Generic simple dual-port RAM with registered read.
module stgvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/segment_table_gc_victim_select.sv
// Segment table with greedy garbage-collection victim selection.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  command  | i_in_valid / o_in_ready   | i_command, i_slot_index, i_segment_kind,
//           |                           | i_live_byte_count
//  result   | o_out_valid / i_out_ready | o_status, o_result_slot,
//           |                           | o_result_identifier, o_victim_percent
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Seal, start-cleaning, free and set-live go through a read, a modify-write and a result step.
// Allocate scans slots from slot 0 up to the first free slot; victim search makes one memory
// read per slot, then passes each slot through the pipelined percent divider.
// After reset a clearing pass writes every slot; no command transfer is taken during
// it. A result waiting on a stalled output does not block the next command transfer,
// only the next result.
module segment_table_gc_victim_select #(
    parameter int SLOT_COUNT = stgvs_pkg::SLOT_COUNT_DEF,
    parameter int KIND_BITS  = stgvs_pkg::KIND_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [9:0]  i_slot_index,
    input  logic [1:0]  i_segment_kind,
    input  logic [31:0] i_live_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [9:0]  o_result_slot,
    output logic [31:0] o_result_identifier,
    output logic [6:0]  o_victim_percent,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import stgvs_pkg::*;

    localparam int SW     = $clog2(SLOT_COUNT);
    localparam int WORD_W = 66 + KIND_BITS;
    localparam int NSTG   = 8;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RMW   = 7'b0000100,
        S_ALLOC = 7'b0001000,
        S_VICT  = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [31:0] r_size;
    logic [6:0]  r_thr;

    // Latched command
    logic [2:0]           r_cmd;
    logic [SW-1:0]        r_idx;
    logic [KIND_BITS-1:0] r_kind;
    logic [31:0]          r_live;
    logic [31:0]          r_next_id;

    // Scan control
    logic [SW:0]   r_scan;
    logic          r_rd_vld;
    logic [SW-1:0] r_rd_addr;

    // Pending result
    logic [1:0]  r_res_st;
    logic [9:0]  r_res_slot;
    logic [31:0] r_res_id;
    logic [6:0]  r_res_pct;

    // Output register
    logic        r_out_vld;
    logic [1:0]  r_o_st;
    logic [9:0]  r_o_slot;
    logic [31:0] r_o_id;
    logic [6:0]  r_o_pct;

    // Victim search best so far
    logic          r_found;
    logic [6:0]    r_best;
    logic [SW-1:0] r_best_slot;
    logic [31:0]   r_best_id;

    // Percent divider pipeline
    logic [39:0]   r_rem  [NSTG];
    logic [6:0]    r_q    [NSTG];
    logic          r_pv   [NSTG];
    logic          r_cand [NSTG];
    logic          r_ovf  [NSTG];
    logic          r_zero [NSTG];
    logic [SW-1:0] r_pslot[NSTG];
    logic [31:0]   r_pid  [NSTG];

    // Memory ports
    logic              mem_we;
    logic [SW-1:0]     mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    logic [1:0]           rd_st;
    logic [KIND_BITS-1:0] rd_kind;
    logic [31:0]          rd_live, rd_id;

    logic [31:0]          idx32;
    logic                 in_range;
    logic [KIND_BITS-1:0] in_kind;
    logic                 in_xfer, issue, scan_live;
    logic [6:0]           q_eff;
    logic                 qual, last_out;
    logic                 out_load;

    stgvs_ram #(.WIDTH(WORD_W), .DEPTH(SLOT_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign rd_id   = mem_rdata[31:0];
    assign rd_live = mem_rdata[63:32];
    assign rd_st   = mem_rdata[65:64];
    assign rd_kind = mem_rdata[WORD_W-1:66];

    assign idx32    = 32'(i_slot_index);
    assign in_range = idx32 < 32'(SLOT_COUNT);
    assign in_kind  = KIND_BITS'(i_segment_kind);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign scan_live   = r_scan < (SW+1)'(SLOT_COUNT);
    assign issue       = scan_live && ((r_state == S_ALLOC) || (r_state == S_VICT));

    // Final divider stage: qualify against threshold and best so far
    assign q_eff    = r_zero[NSTG-1] ? 7'd0 : r_q[NSTG-1];
    assign qual     = r_pv[NSTG-1] && r_cand[NSTG-1] && (r_zero[NSTG-1] || !r_ovf[NSTG-1])
                      && (q_eff < r_thr) && (q_eff < r_best);
    assign last_out = r_pv[NSTG-1] && (r_pslot[NSTG-1] == SW'(SLOT_COUNT - 1));

    assign out_load = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    // Read address selection
    always_comb begin
        if (in_xfer) begin
            mem_raddr = idx32[SW-1:0];
        end else begin
            mem_raddr = r_scan[SW-1:0];
        end
    end

    // Write port: clearing pass, read-modify-write and allocation
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_scan[SW-1:0];
                mem_wdata = '0;
            end
            S_RMW: begin
                case (r_cmd)
                    CMD_SEAL: begin
                        mem_we           = (rd_st == SLOT_ACTIVE);
                        mem_wdata[65:64] = SLOT_SEALED;
                    end
                    CMD_CLEAN: begin
                        mem_we           = (rd_st == SLOT_SEALED);
                        mem_wdata[65:64] = SLOT_CLEAN;
                    end
                    CMD_FREE: begin
                        mem_we           = 1'b1;
                        mem_wdata[65:64] = SLOT_FREE;
                        mem_wdata[63:32] = '0;
                    end
                    default: begin
                        mem_we           = 1'b1;
                        mem_wdata[63:32] = (r_live > r_size) ? r_size : r_live;
                    end
                endcase
            end
            S_ALLOC: begin
                mem_we    = r_rd_vld && (rd_st == SLOT_FREE);
                mem_waddr = r_rd_addr;
                mem_wdata = {r_kind, SLOT_ACTIVE, 32'd0, r_next_id};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_scan == (SW+1)'(SLOT_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_command == CMD_ALLOC) begin
                        n_state = S_ALLOC;
                    end else if (i_command == CMD_VICTIM) begin
                        n_state = S_VICT;
                    end else if (in_range && (i_command == CMD_SEAL || i_command == CMD_CLEAN
                                 || i_command == CMD_FREE || i_command == CMD_SETLIV)) begin
                        n_state = S_RMW;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RMW:   n_state = S_DONE;
            S_ALLOC: begin
                if (r_rd_vld && ((rd_st == SLOT_FREE)
                    || (r_rd_addr == SW'(SLOT_COUNT - 1)))) n_state = S_DONE;
            end
            S_VICT:  if (last_out) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_next_id <= 32'd1;
            r_size    <= '0;
            r_thr     <= '0;
            r_found   <= 1'b0;
            r_best    <= PCT_NO_BEST;
            for (int s = 0; s < NSTG; s++) begin
                r_pv[s] <= 1'b0;
            end
        end else begin
            r_state <= n_state;

            // Configuration transfer
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SIZE)   r_size <= i_cfg_data;
                if (i_cfg_index == CFG_THRESH) r_thr  <= i_cfg_data[6:0];
            end

            // Scan counter
            if (r_state == S_CLEAR) begin
                r_scan <= (r_scan == (SW+1)'(SLOT_COUNT - 1)) ? '0 : r_scan + 1'b1;
            end else if (in_xfer) begin
                r_scan <= '0;
            end else if (issue) begin
                r_scan <= r_scan + 1'b1;
            end
            r_rd_vld <= issue;

            // Advance divider valid bits
            r_pv[0] <= r_rd_vld && (r_state == S_VICT);
            for (int s = 1; s < NSTG; s++) begin
                r_pv[s] <= r_pv[s-1];
            end

            // Track best candidate
            if (in_xfer) begin
                r_found <= 1'b0;
                r_best  <= PCT_NO_BEST;
            end else if (qual) begin
                r_found <= 1'b1;
                r_best  <= q_eff;
            end

            if ((r_state == S_ALLOC) && r_rd_vld && (rd_st == SLOT_FREE)) begin
                r_next_id <= r_next_id + 32'd1;
            end

            // Output register
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_scan[SW-1:0];

        if (in_xfer) begin
            r_cmd  <= i_command;
            r_idx  <= idx32[SW-1:0];
            r_kind <= in_kind;
            r_live <= i_live_byte_count;
            // Commands resolved at transfer
            r_res_st   <= RES_IGNORED;
            r_res_slot <= '0;
            r_res_id   <= '0;
            r_res_pct  <= '0;
        end

        if (r_state == S_RMW) begin
            if ((r_cmd == CMD_SEAL && rd_st != SLOT_ACTIVE)
                || (r_cmd == CMD_CLEAN && rd_st != SLOT_SEALED)) begin
                r_res_st <= RES_IGNORED;
            end else begin
                r_res_st <= RES_DONE;
            end
        end

        if (r_state == S_ALLOC && r_rd_vld) begin
            if (rd_st == SLOT_FREE) begin
                r_res_st   <= RES_DONE;
                r_res_slot <= 10'(32'(r_rd_addr));
                r_res_id   <= r_next_id;
            end else begin
                r_res_st <= RES_NONE;
            end
        end

        if (qual) begin
            r_best_slot <= r_pslot[NSTG-1];
            r_best_id   <= r_pid[NSTG-1];
        end
        if (r_state == S_VICT && last_out) begin
            if (qual || r_found) begin
                r_res_st   <= RES_DONE;
                r_res_slot <= qual ? 10'(32'(r_pslot[NSTG-1])) : 10'(32'(r_best_slot));
                r_res_id   <= qual ? r_pid[NSTG-1] : r_best_id;
                r_res_pct  <= qual ? q_eff : r_best;
            end else begin
                r_res_st <= RES_NONE;
            end
        end

        // Divider entry: scale live bytes by 100
        r_rem[0]   <= 40'(rd_live) * 40'(PCT_SCALE);
        r_q[0]     <= '0;
        r_cand[0]  <= (rd_st == SLOT_SEALED) && (rd_kind == r_kind);
        r_ovf[0]   <= 1'b0;
        r_zero[0]  <= (r_size == 32'd0);
        r_pslot[0] <= r_rd_addr;
        r_pid[0]   <= rd_id;

        // Restoring division, one quotient bit per stage
        for (int s = 0; s < NSTG - 1; s++) begin
            if (r_rem[s] >= (40'(r_size) << (6 - s))) begin
                r_rem[s+1] <= r_rem[s] - (40'(r_size) << (6 - s));
                r_q[s+1]   <= r_q[s] | (7'd1 << (6 - s));
            end else begin
                r_rem[s+1] <= r_rem[s];
                r_q[s+1]   <= r_q[s];
            end
            r_ovf[s+1]   <= r_ovf[s] || ((s == 0) && (r_rem[s] >= (40'(r_size) << 7)));
            r_cand[s+1]  <= r_cand[s];
            r_zero[s+1]  <= r_zero[s];
            r_pslot[s+1] <= r_pslot[s];
            r_pid[s+1]   <= r_pid[s];
        end

        if (out_load) begin
            r_o_st   <= r_res_st;
            r_o_slot <= r_res_slot;
            r_o_id   <= r_res_id;
            r_o_pct  <= r_res_pct;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_status            = r_o_st;
    assign o_result_slot       = r_o_slot;
    assign o_result_identifier = r_o_id;
    assign o_victim_percent    = r_o_pct;
endmodule
